FILE: design/scp_pkg.sv
// shared types and constants of the set-associative cache with next-line prefetch
// no dependencies; compile first
package scp_pkg;

    // default sizes, handed to the top level parameters
    localparam int SETS_DEF         = 64;
    localparam int WAYS_DEF         = 8;
    localparam int ADDR_BITS_DEF    = 48;
    localparam int MAX_PREFETCH_DEF = 8;

    // configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 8;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_OFFSET_BITS    = 4'd0,
        CFG_INDEX_BITS     = 4'd1,
        CFG_WAYS_IN_USE    = 4'd2,
        CFG_PREFETCH_COUNT = 4'd3
    } t_cfg_reg;

    localparam logic [3:0] RST_OFFSET_BITS    = 4'd4;
    localparam logic [2:0] RST_INDEX_BITS     = 3'd6;
    localparam logic [3:0] RST_WAYS_IN_USE    = 4'd1;
    localparam logic [3:0] RST_PREFETCH_COUNT = 4'd1;

    // request kinds
    localparam logic REQ_READ  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam int PF_OUT_W = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_RUN,
        S_HOLD
    } t_state;

    // one result transaction
    typedef struct packed {
        logic                hit;
        logic                demand_read;
        logic                mem_write;
        logic [PF_OUT_W-1:0] prefetch_reads;
    } t_result;

    // status of one set lookup
    typedef struct packed {
        logic hit;
        logic used_free;
    } t_upd;

endpackage

FILE: design/scp_if.sv
// channel interfaces: request, response and configuration write
// depends on scp_pkg
interface scp_req_if #(
    parameter int ADDR_BITS = scp_pkg::ADDR_BITS_DEF
);
    logic                 valid;
    logic                 ready;
    logic                 req_type;
    logic [ADDR_BITS-1:0] address;

    modport source (output valid, output req_type, output address, input ready);
    modport sink   (input valid, input req_type, input address, output ready);
endinterface

interface scp_rsp_if;
    import scp_pkg::*;
    logic                valid;
    logic                ready;
    logic                hit;
    logic                demand_read;
    logic                mem_write;
    logic [PF_OUT_W-1:0] prefetch_reads;

    modport source (output valid, output hit, output demand_read, output mem_write,
                    output prefetch_reads, input ready);
    modport sink   (input valid, input hit, input demand_read, input mem_write,
                    input prefetch_reads, output ready);
endinterface

interface scp_cfg_if;
    import scp_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: design/scp_ram.sv
// generic single-port-write, single-port-read ram with registered read
// no dependencies
module scp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

FILE: design/scp_set_upd.sv
// tag compare and fifo fill of one set row
// depends on scp_pkg (t_upd)
module scp_set_upd #(
    parameter int WAYS      = scp_pkg::WAYS_DEF,
    parameter int ADDR_BITS = scp_pkg::ADDR_BITS_DEF
) (
    input  logic [WAYS*ADDR_BITS+WAYS+((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] i_row,
    input  logic [ADDR_BITS-1:0]                                           i_tag,
    input  logic [$clog2(WAYS+1)-1:0]                                      i_n_ways,
    output logic [WAYS*ADDR_BITS+WAYS+((WAYS > 1) ? $clog2(WAYS) : 1)-1:0] o_row,
    output scp_pkg::t_upd                                                  o_st
);
    import scp_pkg::*;

    localparam int OW   = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAYW = $clog2(WAYS + 1);
    localparam int TW   = WAYS * ADDR_BITS;

    logic [ADDR_BITS-1:0] tags     [WAYS];
    logic [ADDR_BITS-1:0] new_tags [WAYS];
    logic [WAYS-1:0]      valid;
    logic [WAYS-1:0]      new_valid;
    logic [WAYS-1:0]      in_use;
    logic [WAYS-1:0]      match;
    logic [OW-1:0]        oldest;
    logic [OW-1:0]        new_oldest;
    logic [OW-1:0]        free_way;
    logic                 found;
    logic [WAYW-1:0]      old_w;
    logic [WAYW-1:0]      vic;
    logic [WAYW:0]        vic_inc;
    logic [OW-1:0]        victim;

    always_comb begin
        valid  = i_row[TW +: WAYS];
        oldest = i_row[TW+WAYS +: OW];
        for (int w = 0; w < WAYS; w++) begin
            tags[w]   = i_row[w*ADDR_BITS +: ADDR_BITS];
            in_use[w] = (WAYW'(w) < i_n_ways);
            match[w]  = valid[w] && in_use[w] && (tags[w] == i_tag);
        end

        // lowest free way in use wins
        found    = 1'b0;
        free_way = '0;
        for (int w = WAYS - 1; w >= 0; w--) begin
            if (in_use[w] && !valid[w]) begin
                found    = 1'b1;
                free_way = OW'(w);
            end
        end

        // stale pointer beyond the ways in use falls back to way 0
        old_w   = WAYW'(oldest);
        vic     = (old_w >= i_n_ways) ? '0 : old_w;
        vic_inc = {1'b0, vic} + 1'b1;
        victim  = found ? free_way : OW'(vic);

        new_oldest = found ? oldest
                   : ((vic_inc >= {1'b0, i_n_ways}) ? '0 : OW'(vic_inc));
        new_valid  = valid;
        for (int w = 0; w < WAYS; w++) begin
            new_tags[w] = tags[w];
        end
        new_valid[victim] = 1'b1;
        new_tags[victim]  = i_tag;

        for (int w = 0; w < WAYS; w++) begin
            o_row[w*ADDR_BITS +: ADDR_BITS] = new_tags[w];
        end
        o_row[TW +: WAYS]    = new_valid;
        o_row[TW+WAYS +: OW] = new_oldest;

        o_st.hit       = |match;
        o_st.used_free = found;
    end
endmodule

FILE: design/set_assoc_cache_fifo_prefetch.sv
// top level: write-through set-associative cache model with fifo replacement
// and next-line prefetch; depends on scp_pkg, scp_if, scp_ram, scp_set_upd
//
//  port    | dir | transaction
//  --------+-----+----------------------------------------------------------
//  i_req   | in  | one access: req_type, address
//  o_rsp   | out | one result: hit, demand_read, mem_write, prefetch_reads
//  i_cfg   | in  | register write: index, data (always ready)
//
// an access does one set lookup on a demand hit, and 1 + min(prefetch_count,
// MAX_PREFETCH) lookups on a miss: the demand block and the blocks after it.
// each lookup is a registered read of the set row ram, overlapped with
// the compare and any write back of the previous lookup; a row written in the
// cycle a lookup reads it is forwarded. a new access is taken while the last
// result still waits in the output register; the core holds only when a
// second result is ready before the first was taken. reset clears the per-set
// row flags at once, so no clearing pass is needed.
module set_assoc_cache_fifo_prefetch #(
    parameter int SETS         = scp_pkg::SETS_DEF,
    parameter int WAYS         = scp_pkg::WAYS_DEF,
    parameter int ADDR_BITS    = scp_pkg::ADDR_BITS_DEF,
    parameter int MAX_PREFETCH = scp_pkg::MAX_PREFETCH_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    scp_req_if.sink    i_req,
    scp_rsp_if.source  o_rsp,
    scp_cfg_if.sink    i_cfg
);
    import scp_pkg::*;

    localparam int SW      = (SETS > 1) ? $clog2(SETS) : 1;
    localparam int SET_LOG = $clog2(SETS + 1) - 1;
    localparam int OW      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int WAYW    = $clog2(WAYS + 1);
    localparam int KW      = $clog2(MAX_PREFETCH + 1);
    localparam int RW      = WAYS * ADDR_BITS + WAYS + OW;

    // configuration
    logic [3:0] r_off;
    logic [2:0] r_ib;
    logic [3:0] r_ways;
    logic [3:0] r_pfc;

    logic [2:0]      eib;
    logic [WAYW-1:0] n_ways;
    logic [KW-1:0]   eff_cnt;

    // control and datapath registers
    t_state               r_state, n_state;
    logic [KW-1:0]        r_dk, n_dk;
    logic [KW-1:0]        r_cnt, n_cnt;
    logic [KW-1:0]        r_pf, n_pf;
    logic                 r_req, n_req;
    logic [ADDR_BITS-1:0] r_iaddr, n_iaddr;
    logic [SW-1:0]        r_dset, n_dset;
    logic [ADDR_BITS-1:0] r_dtag, n_dtag;
    logic                 r_fwd_vld, n_fwd_vld;
    logic [SW-1:0]        r_fwd_set;
    logic [RW-1:0]        r_fwd_row;
    logic [SETS-1:0]      r_row_init;
    t_result              r_out, n_out;
    logic                 r_out_vld, n_out_vld;
    t_result              r_pend, n_pend;

    logic                 in_acc;
    logic                 out_free;
    logic [ADDR_BITS-1:0] blk_size;
    logic [ADDR_BITS-1:0] iss_addr;
    logic [ADDR_BITS-1:0] iss_blk;
    logic [SW-1:0]        set_mask;
    logic [SW-1:0]        iss_set;
    logic [ADDR_BITS-1:0] iss_tag;
    logic                 ram_re;
    logic                 ram_we;
    logic [RW-1:0]        ram_rdata;
    logic [RW-1:0]        row_cur;
    logic [RW-1:0]        row_new;
    t_upd                 st;
    logic                 done;
    logic [KW-1:0]        pf_next;
    t_result              res;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_state == S_IDLE);
    assign in_acc      = i_req.valid && (r_state == S_IDLE);
    assign out_free    = !r_out_vld || o_rsp.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off  <= RST_OFFSET_BITS;
            r_ib   <= RST_INDEX_BITS;
            r_ways <= RST_WAYS_IN_USE;
            r_pfc  <= RST_PREFETCH_COUNT;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_OFFSET_BITS:    r_off  <= i_cfg.data[3:0];
                CFG_INDEX_BITS:     r_ib   <= i_cfg.data[2:0];
                CFG_WAYS_IN_USE:    r_ways <= i_cfg.data[3:0];
                CFG_PREFETCH_COUNT: r_pfc  <= i_cfg.data[3:0];
                default: ;
            endcase
        end
    end

    // effective settings after clamping
    always_comb begin
        eib = (32'(r_ib) > SET_LOG) ? 3'(SET_LOG) : r_ib;
        if (r_ways == 4'd0) begin
            n_ways = WAYW'(1);
        end else if (32'(r_ways) > WAYS) begin
            n_ways = WAYW'(WAYS);
        end else begin
            n_ways = WAYW'(r_ways);
        end
        eff_cnt = (32'(r_pfc) > MAX_PREFETCH) ? KW'(MAX_PREFETCH) : KW'(r_pfc);
    end

    // address split for the lookup being issued
    always_comb begin
        blk_size = ADDR_BITS'(1) << r_off;
        iss_addr = (r_state == S_IDLE) ? i_req.address : r_iaddr;
        iss_blk  = iss_addr >> r_off;
        set_mask = SW'((32'd1 << eib) - 32'd1);
        iss_set  = SW'(iss_blk) & set_mask;
        iss_tag  = iss_blk >> eib;
    end

    scp_ram #(
        .WIDTH (RW),
        .DEPTH (SETS)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_dset),
        .i_wdata (row_new),
        .i_re    (ram_re),
        .i_raddr (iss_set),
        .o_rdata (ram_rdata)
    );

    // a row never written since reset reads as all ways invalid, pointer 0
    always_comb begin
        if (r_fwd_vld && (r_fwd_set == r_dset)) begin
            row_cur = r_fwd_row;
        end else if (r_row_init[r_dset]) begin
            row_cur = ram_rdata;
        end else begin
            row_cur = '0;
        end
    end

    scp_set_upd #(
        .WAYS      (WAYS),
        .ADDR_BITS (ADDR_BITS)
    ) u_upd (
        .i_row    (row_cur),
        .i_tag    (r_dtag),
        .i_n_ways (n_ways),
        .o_row    (row_new),
        .o_st     (st)
    );

    always_comb begin
        done               = ((r_dk == '0) && st.hit) || (r_dk == r_cnt);
        pf_next            = r_pf + KW'((r_dk != '0) && !st.hit);
        res.hit            = (r_dk == '0) && st.hit;
        res.demand_read    = !res.hit;
        res.mem_write      = (r_req == REQ_WRITE);
        res.prefetch_reads = PF_OUT_W'(pf_next);
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = S_RUN;
                end
            end
            S_RUN: begin
                if (done) begin
                    n_state = out_free ? S_IDLE : S_HOLD;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        ram_re    = 1'b0;
        ram_we    = 1'b0;
        n_dk      = r_dk;
        n_cnt     = r_cnt;
        n_pf      = r_pf;
        n_req     = r_req;
        n_iaddr   = r_iaddr;
        n_dset    = r_dset;
        n_dtag    = r_dtag;
        n_fwd_vld = 1'b0;
        n_pend    = r_pend;
        n_out     = r_out;
        n_out_vld = r_out_vld && !o_rsp.ready;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    ram_re  = 1'b1;
                    n_dk    = '0;
                    n_cnt   = eff_cnt;
                    n_pf    = '0;
                    n_req   = i_req.req_type;
                    n_iaddr = i_req.address + blk_size;
                    n_dset  = iss_set;
                    n_dtag  = iss_tag;
                end
            end
            S_RUN: begin
                ram_we    = !st.hit;
                n_fwd_vld = !st.hit;
                n_pf      = pf_next;
                if (done) begin
                    if (out_free) begin
                        n_out     = res;
                        n_out_vld = 1'b1;
                    end else begin
                        n_pend = res;
                    end
                end else begin
                    // next block is read while this one's row is written back on a miss
                    ram_re  = 1'b1;
                    n_dk    = r_dk + 1'b1;
                    n_iaddr = r_iaddr + blk_size;
                    n_dset  = iss_set;
                    n_dtag  = iss_tag;
                end
            end
            S_HOLD: begin
                if (out_free) begin
                    n_out     = r_pend;
                    n_out_vld = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_fwd_vld  <= 1'b0;
            r_out_vld  <= 1'b0;
            r_row_init <= '0;
        end else begin
            r_state   <= n_state;
            r_fwd_vld <= n_fwd_vld;
            r_out_vld <= n_out_vld;
            if (ram_we) begin
                r_row_init[r_dset] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_dk      <= n_dk;
        r_cnt     <= n_cnt;
        r_pf      <= n_pf;
        r_req     <= n_req;
        r_iaddr   <= n_iaddr;
        r_dset    <= n_dset;
        r_dtag    <= n_dtag;
        r_pend    <= n_pend;
        r_out     <= n_out;
        r_fwd_set <= r_dset;
        r_fwd_row <= row_new;
    end

    assign o_rsp.valid          = r_out_vld;
    assign o_rsp.hit            = r_out.hit;
    assign o_rsp.demand_read    = r_out.demand_read;
    assign o_rsp.mem_write      = r_out.mem_write;
    assign o_rsp.prefetch_reads = r_out.prefetch_reads;

    a_we_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_RUN))
        else $error("row write outside lookup sequence");

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) |-> (r_dk <= r_cnt))
        else $error("lookup step beyond prefetch count");

    a_hit_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.hit) |-> (!o_rsp.demand_read && (o_rsp.prefetch_reads == '0)))
        else $error("hit result reports memory reads");

    a_no_stale_fwd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc |=> !r_fwd_vld)
        else $error("forwarded row carried into a new access");
endmodule
